>>> design/alu16_pkg.sv
// ----------------------------------------------------------------------------
// alu16_pkg
// Shared types for the 16-bit add/subtract/multiply ALU with flags.
// ----------------------------------------------------------------------------
package alu16_pkg;

  localparam int unsigned WordW = 16;

  typedef enum logic [1:0] {
    FUNC_ADC  = 2'd0,
    FUNC_SBC  = 2'd1,
    FUNC_UMUL = 2'd2,
    FUNC_SMUL = 2'd3
  } func_e;

  typedef struct packed {
    logic n;
    logic v;
    logic z;
    logic c;
  } flags_t;

  // operands as held in the input register
  typedef struct packed {
    func_e            func;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] ma;
    logic [WordW-1:0] mb;
    logic             sgn_diff;
    flags_t           flags;
  } issue_t;

  typedef struct packed {
    logic [WordW-1:0] r;
    flags_t           flags;
  } result_t;

endpackage

>>> design/alu16_opnd.sv
// ----------------------------------------------------------------------------
// alu16_opnd
// Input register: captures a transaction and prepares the multiplier operands
// (raw words for unsigned, magnitudes for signed multiply).
// ----------------------------------------------------------------------------
module alu16_opnd import alu16_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [1:0]       func_i,
  input  logic [WordW-1:0] left_value_i,
  input  logic [WordW-1:0] right_value_i,
  input  flags_t           flags_i,
  output logic             valid_o,
  output issue_t           issue_o
);

  logic   valid_q;
  issue_t issue_d, issue_q;
  logic   sa, sb;

  always_comb begin
    sa = left_value_i[WordW-1];
    sb = right_value_i[WordW-1];
    issue_d.func     = func_e'(func_i);
    issue_d.a        = left_value_i;
    issue_d.b        = right_value_i;
    issue_d.sgn_diff = sa ^ sb;
    issue_d.flags    = flags_i;
    // two's complement negate also gives 0x8000 its magnitude 0x8000
    if (func_e'(func_i) == FUNC_SMUL && sa) begin
      issue_d.ma = ~left_value_i + WordW'(1);
    end else begin
      issue_d.ma = left_value_i;
    end
    if (func_e'(func_i) == FUNC_SMUL && sb) begin
      issue_d.mb = ~right_value_i + WordW'(1);
    end else begin
      issue_d.mb = right_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      issue_q <= issue_d;
    end
  end

  assign valid_o = valid_q;
  assign issue_o = issue_q;

endmodule

>>> design/alu16_exec.sv
// ----------------------------------------------------------------------------
// alu16_exec
// Execute logic: carry adder and 16x16 multiplier with overflow and flag
// update.
// ----------------------------------------------------------------------------
module alu16_exec import alu16_pkg::*; (
  input  issue_t  issue_i,
  output result_t result_o
);

  logic [WordW-1:0]   bb;
  logic [WordW:0]     sum;
  logic [2*WordW-1:0] prod;
  logic               ovf_u, ovf_s;

  always_comb begin
    bb    = (issue_i.func == FUNC_SBC) ? ~issue_i.b : issue_i.b;
    sum   = {1'b0, issue_i.a} + {1'b0, bb} + {{WordW{1'b0}}, issue_i.flags.c};
    prod  = {{WordW{1'b0}}, issue_i.ma} * {{WordW{1'b0}}, issue_i.mb};
    ovf_u = |prod[2*WordW-1:WordW];
    ovf_s = |prod[2*WordW-1:WordW-1];

    result_o.r     = issue_i.a;
    result_o.flags = issue_i.flags;
    case (issue_i.func)
      FUNC_ADC, FUNC_SBC: begin
        result_o.r       = sum[WordW-1:0];
        result_o.flags.c = sum[WordW];
        result_o.flags.v = ~(issue_i.a[WordW-1] ^ bb[WordW-1])
                           & (issue_i.a[WordW-1] ^ sum[WordW-1]);
        result_o.flags.n = sum[WordW-1];
        result_o.flags.z = (sum[WordW-1:0] == '0);
      end
      FUNC_UMUL: begin
        if (ovf_u) begin
          result_o.flags.v = 1'b1;
        end else begin
          result_o.r = prod[WordW-1:0];
        end
      end
      default: begin
        if (ovf_s) begin
          result_o.flags.v = 1'b1;
        end else if (issue_i.sgn_diff) begin
          result_o.r = ~prod[WordW-1:0] + WordW'(1);
        end else begin
          result_o.r = prod[WordW-1:0];
        end
        result_o.flags.n = issue_i.sgn_diff & (prod != '0);
      end
    endcase
  end

endmodule

>>> design/alu16_add_sub_mul_flags_core.sv
// ----------------------------------------------------------------------------
// alu16_add_sub_mul_flags_core
// 16-bit ALU: add with carry, subtract with borrow, unsigned and signed
// multiply, with N/V/Z/C flag update.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken on a rising edge with start_i high and busy_o low.
//   busy_o is always low: a new transaction may be issued every cycle.
//   Each transaction goes through an input register and a result register;
//   its result appears from the result register with done_o high for
//   exactly one cycle alongside result_value_o and the four flags.
//   Throughput is one transaction per cycle; the stage between the two
//   registers holds the 16x16 multiplier and the carry adder.
//   Results keep issue order. The receiver cannot stall: every result must
//   be taken in its done_o cycle.
//   Reset clears both valid bits, so no done_o follows reset until a new
//   transaction is issued; in-flight transactions are dropped.
// ----------------------------------------------------------------------------
module alu16_add_sub_mul_flags_core import alu16_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [1:0]       func_i,
  input  logic [WordW-1:0] left_value_i,
  input  logic [WordW-1:0] right_value_i,
  input  logic             neg_in_i,
  input  logic             ovf_in_i,
  input  logic             zero_in_i,
  input  logic             carry_in_i,
  output logic             done_o,
  output logic [WordW-1:0] result_value_o,
  output logic             neg_out_o,
  output logic             ovf_out_o,
  output logic             zero_out_o,
  output logic             carry_out_o
);

  logic    take;
  logic    iss_valid;
  issue_t  issue;
  result_t res_d, res_q;
  logic    done_q;
  flags_t  flags_in;

  assign busy_o = 1'b0;
  assign take   = start_i & ~busy_o;

  assign flags_in = '{n: neg_in_i, v: ovf_in_i, z: zero_in_i, c: carry_in_i};

  alu16_opnd u_opnd (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .func_i        (func_i),
    .left_value_i  (left_value_i),
    .right_value_i (right_value_i),
    .flags_i       (flags_in),
    .valid_o       (iss_valid),
    .issue_o       (issue)
  );

  alu16_exec u_exec (
    .issue_i  (issue),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= iss_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (iss_valid) begin
      res_q <= res_d;
    end
  end

  assign done_o         = done_q;
  assign result_value_o = res_q.r;
  assign neg_out_o      = res_q.flags.n;
  assign ovf_out_o      = res_q.flags.v;
  assign zero_out_o     = res_q.flags.z;
  assign carry_out_o    = res_q.flags.c;

endmodule

>>> design/alu16_chk.sv
// ----------------------------------------------------------------------------
// alu16_chk
// Port-level checks for the ALU core, bound to the top level.
// ----------------------------------------------------------------------------
module alu16_chk import alu16_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input logic [1:0]       func_i,
  input logic [WordW-1:0] left_value_i,
  input logic             ovf_in_i,
  input logic             done_o,
  input logic [WordW-1:0] result_value_o,
  input logic             neg_out_o,
  input logic             ovf_out_o,
  input logic             zero_out_o
);

  // every accepted transaction gives a result through the input and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> ##1 done_o)
    else $error("missing result two cycles after transaction");

  // no result without a transaction
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 2))
    else $error("result without transaction");

  // add and subtract N and Z flags follow the result word
  a_addsub_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ($past(func_i, 2) == FUNC_ADC || $past(func_i, 2) == FUNC_SBC)
    |-> (neg_out_o == result_value_o[WordW-1])
        && (zero_out_o == (result_value_o == '0)))
    else $error("N/Z do not match result");

  // multiply keeps the accumulator when V is newly raised
  a_mul_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && ($past(func_i, 2) == FUNC_UMUL || $past(func_i, 2) == FUNC_SMUL)
    && ovf_out_o && !$past(ovf_in_i, 2)
    |-> result_value_o == $past(left_value_i, 2))
    else $error("multiply overflow changed accumulator");

endmodule

bind alu16_add_sub_mul_flags_core alu16_chk u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .func_i         (func_i),
  .left_value_i   (left_value_i),
  .ovf_in_i       (ovf_in_i),
  .done_o         (done_o),
  .result_value_o (result_value_o),
  .neg_out_o      (neg_out_o),
  .ovf_out_o      (ovf_out_o),
  .zero_out_o     (zero_out_o)
);

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 16-bit add/subtract/multiply ALU with flags.
// A queue of operations feeds a clocked driver; each accepted transaction is
// run through a local ALU model and its result queued. A clocked monitor
// takes every done_o result and checks it against the oldest prediction.
// Stimulus is a directed corner set followed by random phases with varying
// sender idle rates.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import alu16_pkg::*;

  typedef struct {
    func_e            func;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic             n;
    logic             v;
    logic             z;
    logic             c;
    int unsigned      idle_pct;
    bit               drain_first;
  } alu_op_t;

  typedef struct {
    logic [WordW-1:0] r;
    logic             n;
    logic             v;
    logic             z;
    logic             c;
  } alu_res_t;

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             start_i        = 1'b0;
  logic [1:0]       func_i         = FUNC_ADC;
  logic [WordW-1:0] left_value_i   = '0;
  logic [WordW-1:0] right_value_i  = '0;
  logic             neg_in_i       = 1'b0;
  logic             ovf_in_i       = 1'b0;
  logic             zero_in_i      = 1'b0;
  logic             carry_in_i     = 1'b0;
  logic             busy_o;
  logic             done_o;
  logic [WordW-1:0] result_value_o;
  logic             neg_out_o;
  logic             ovf_out_o;
  logic             zero_out_o;
  logic             carry_out_o;

  localparam int unsigned WatchdogLimit = 500;
  localparam int unsigned PhaseOps      = 382;

  alu_op_t     pending_ops[$];
  alu_res_t    predicted_results[$];
  alu_op_t     issued_op;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  alu16_add_sub_mul_flags_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .func_i         (func_i),
    .left_value_i   (left_value_i),
    .right_value_i  (right_value_i),
    .neg_in_i       (neg_in_i),
    .ovf_in_i       (ovf_in_i),
    .zero_in_i      (zero_in_i),
    .carry_in_i     (carry_in_i),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .neg_out_o      (neg_out_o),
    .ovf_out_o      (ovf_out_o),
    .zero_out_o     (zero_out_o),
    .carry_out_o    (carry_out_o)
  );

  initial begin
    forever #5ns clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic alu_res_t compute_alu_result(alu_op_t op);
    logic [WordW-1:0] bb;
    logic [WordW:0]   sum;
    logic [WordW-1:0] ma;
    logic [WordW-1:0] mb;
    logic [31:0]      prod;
    logic             sa;
    logic             sb;
    alu_res_t         res;
    res.r = op.a;
    res.n = op.n;
    res.v = op.v;
    res.z = op.z;
    res.c = op.c;
    case (op.func)
      FUNC_ADC, FUNC_SBC: begin
        bb    = (op.func == FUNC_SBC) ? ~op.b : op.b;
        sum   = {1'b0, op.a} + {1'b0, bb} + {{WordW{1'b0}}, op.c};
        res.r = sum[WordW-1:0];
        res.c = sum[WordW];
        res.v = ~(op.a[WordW-1] ^ bb[WordW-1]) & (op.a[WordW-1] ^ sum[WordW-1]);
        res.n = sum[WordW-1];
        res.z = (sum[WordW-1:0] == '0);
      end
      FUNC_UMUL: begin
        prod = {16'h0000, op.a} * {16'h0000, op.b};
        if (prod > 32'h0000_FFFF) begin
          res.v = 1'b1;
        end else begin
          res.r = prod[WordW-1:0];
        end
      end
      default: begin
        sa   = op.a[WordW-1];
        sb   = op.b[WordW-1];
        ma   = sa ? (~op.a + 16'd1) : op.a;
        mb   = sb ? (~op.b + 16'd1) : op.b;
        prod = {16'h0000, ma} * {16'h0000, mb};
        if (prod > 32'h0000_7FFF) begin
          res.v = 1'b1;
        end else begin
          res.r = (sa != sb) ? (~prod[WordW-1:0] + 16'd1) : prod[WordW-1:0];
        end
        res.n = (sa != sb) && (prod != 32'd0);
      end
    endcase
    return res;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        predicted_results.push_back(compute_alu_result(issued_op));
      end
      if (start_i && busy_o) begin
        start_i <= 1'b1;
      end else if (pending_ops.size() != 0 &&
                   (!pending_ops[0].drain_first || predicted_results.size() == 0) &&
                   $urandom_range(99) >= pending_ops[0].idle_pct) begin
        issued_op      = pending_ops.pop_front();
        start_i       <= 1'b1;
        func_i        <= issued_op.func;
        left_value_i  <= issued_op.a;
        right_value_i <= issued_op.b;
        neg_in_i      <= issued_op.n;
        ovf_in_i      <= issued_op.v;
        zero_in_i     <= issued_op.z;
        carry_in_i    <= issued_op.c;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    alu_res_t exp_res;
    if (rst_ni && done_o) begin
      if (predicted_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result r=%h nvzc=%b%b%b%b", $time, result_value_o,
                 neg_out_o, ovf_out_o, zero_out_o, carry_out_o);
      end else begin
        exp_res = predicted_results.pop_front();
        if (result_value_o !== exp_res.r || neg_out_o !== exp_res.n ||
            ovf_out_o !== exp_res.v || zero_out_o !== exp_res.z ||
            carry_out_o !== exp_res.c) begin
          mismatch_count++;
          $display("%0t: mismatch expected r=%h nvzc=%b%b%b%b actual r=%h nvzc=%b%b%b%b",
                   $time, exp_res.r, exp_res.n, exp_res.v, exp_res.z, exp_res.c,
                   result_value_o, neg_out_o, ovf_out_o, zero_out_o, carry_out_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_op(func_e func, logic [WordW-1:0] a, logic [WordW-1:0] b,
                          logic [3:0] nvzc, int unsigned idle_pct, bit drain_first);
    alu_op_t op;
    op.func        = func;
    op.a           = a;
    op.b           = b;
    {op.n, op.v, op.z, op.c} = nvzc;
    op.idle_pct    = idle_pct;
    op.drain_first = drain_first;
    pending_ops.push_back(op);
  endtask

  function automatic logic [WordW-1:0] pick_word();
    logic [WordW-1:0] w;
    case ($urandom_range(5))
      0, 1: w = 16'($urandom);
      2: w = 16'($urandom_range(255));
      3: w = 16'hFFFF - 16'($urandom_range(255));
      4: w = 16'($urandom_range(181));
      default: begin
        case ($urandom_range(5))
          0: w = 16'h0000;
          1: w = 16'h0001;
          2: w = 16'h7FFF;
          3: w = 16'h8000;
          4: w = 16'hFFFF;
          default: w = 16'h00FF;
        endcase
      end
    endcase
    return w;
  endfunction

  initial begin
    int unsigned phase_idle[4];
    phase_idle = '{0, 47, 0, 29};

    // add with carry: carry out, signed overflow, zero result
    queue_op(FUNC_ADC, 16'h0000, 16'h0000, 4'b0000, 0, 1'b0);
    queue_op(FUNC_ADC, 16'hFFFF, 16'h0001, 4'b1110, 0, 1'b0);
    queue_op(FUNC_ADC, 16'h7FFF, 16'h0001, 4'b0000, 0, 1'b0);
    queue_op(FUNC_ADC, 16'h8000, 16'h8000, 4'b0001, 0, 1'b0);
    queue_op(FUNC_ADC, 16'hFFFF, 16'hFFFF, 4'b0001, 0, 1'b0);
    // subtract with borrow
    queue_op(FUNC_SBC, 16'h0000, 16'h0001, 4'b0001, 0, 1'b0);
    queue_op(FUNC_SBC, 16'h1234, 16'h1234, 4'b0001, 0, 1'b0);
    queue_op(FUNC_SBC, 16'h8000, 16'h0001, 4'b0001, 0, 1'b0);
    queue_op(FUNC_SBC, 16'h7FFF, 16'hFFFF, 4'b0001, 0, 1'b0);
    queue_op(FUNC_SBC, 16'h0000, 16'h0000, 4'b1110, 0, 1'b0);
    queue_op(FUNC_SBC, 16'hFFFF, 16'hFFFF, 4'b0000, 0, 1'b0);
    // unsigned multiply: zero operand, exact fit, overflow
    queue_op(FUNC_UMUL, 16'h0000, 16'hFFFF, 4'b1011, 0, 1'b0);
    queue_op(FUNC_UMUL, 16'h00FF, 16'h0101, 4'b0100, 0, 1'b0);
    queue_op(FUNC_UMUL, 16'hFFFF, 16'hFFFF, 4'b0000, 0, 1'b0);
    queue_op(FUNC_UMUL, 16'h0100, 16'h0100, 4'b1111, 0, 1'b0);
    queue_op(FUNC_UMUL, 16'h0001, 16'h7FFF, 4'b0010, 0, 1'b0);
    // signed multiply: most negative operand, sign mix, zero product
    queue_op(FUNC_SMUL, 16'h8000, 16'h0001, 4'b0000, 0, 1'b0);
    queue_op(FUNC_SMUL, 16'h8000, 16'h0000, 4'b1111, 0, 1'b0);
    queue_op(FUNC_SMUL, 16'hFFFF, 16'h7FFF, 4'b0000, 0, 1'b0);
    queue_op(FUNC_SMUL, 16'hFFFF, 16'hFFFF, 4'b1101, 0, 1'b0);
    queue_op(FUNC_SMUL, 16'h0000, 16'hFFFF, 4'b1010, 0, 1'b0);
    queue_op(FUNC_SMUL, 16'h8000, 16'h8000, 4'b0001, 0, 1'b0);
    queue_op(FUNC_SMUL, 16'hFF00, 16'h0100, 4'b0000, 0, 1'b0);
    queue_op(FUNC_SMUL, 16'h00B5, 16'hFF4B, 4'b0110, 0, 1'b0);

    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < PhaseOps; i++) begin
        queue_op(func_e'($urandom_range(3)), pick_word(), pick_word(),
                 4'($urandom_range(15)), phase_idle[p], i == 0);
      end
    end

    @(posedge rst_ni);
    while (pending_ops.size() != 0 || start_i) @(posedge clk_i);
    while (predicted_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (predicted_results.size() != 0) mismatch_count++;

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
